@@ design/escaped_frame_receiver_crc_check_unit_macros.svh @@
// Assertion helpers shared by the receiver modules.
// Each check is clocked on clk and is held off while rst_n is low.
`ifndef ESCAPED_FRAME_RECEIVER_CRC_CHECK_UNIT_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CRC_CHECK_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ERX_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ERX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ERX_ASSERT_SAME(lbl, ante, cons, msg)
`define ERX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/erx_pkg.sv @@
package erx_pkg;

    // Configuration register indexes.
    localparam logic CFG_ESCAPE_CHAR = 1'b0;
    localparam logic CFG_END_CHAR    = 1'b1;

    localparam logic [7:0] ESCAPE_CHAR_RESET = 8'd241;
    localparam logic [7:0] END_CHAR_RESET    = 8'd242;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

    localparam int unsigned MIN_FRAME_LEN = 3;
    localparam int unsigned LEN_W         = 9;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // One decoded symbol passed from the front end to the frame engine.
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } sym_t;

    // One result beat.
    typedef struct packed {
        logic             is_command_code;
        logic             kind;
        logic [LEN_W-1:0] frame_length;
        logic [1:0]       frame_status;
        logic [7:0]       data;
    } result_t;

    // Queue occupancy flags seen by the front end and the frame engine.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Bytewise CRC-16/ARC step, reflected, LSB first.
    function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ design/erx_front.sv @@
module erx_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  erx_pkg::qstat_t     qstat,
    output logic                push,
    output erx_pkg::sym_t       push_sym
);

`include "escaped_frame_receiver_crc_check_unit_macros.svh"

    logic [7:0] escape_char_reg;
    logic [7:0] end_char_reg;
    logic       esc_pending_reg;
    logic       esc_pending_next;
    logic       accept;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    // A byte after an escape is always data; escape wins over end.
    always_comb
    begin
        esc_pending_next = esc_pending_reg;
        push             = 1'b0;
        push_sym.is_end  = 1'b0;
        push_sym.data    = s_tdata;
        if (accept)
        begin
            priority if (esc_pending_reg)
            begin
                esc_pending_next = 1'b0;
                push             = 1'b1;
            end
            else if (s_tdata == escape_char_reg)
            begin
                esc_pending_next = 1'b1;
            end
            else if (s_tdata == end_char_reg)
            begin
                push            = 1'b1;
                push_sym.is_end = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_char_reg <= erx_pkg::ESCAPE_CHAR_RESET;
            end_char_reg    <= erx_pkg::END_CHAR_RESET;
            esc_pending_reg <= 1'b0;
        end
        else
        begin
            esc_pending_reg <= esc_pending_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    erx_pkg::CFG_ESCAPE_CHAR: escape_char_reg <= cfg_wdata;
                    erx_pkg::CFG_END_CHAR:    end_char_reg    <= cfg_wdata;
                    default:                  escape_char_reg <= escape_char_reg;
                endcase
            end
        end
    end

    `ERX_ASSERT_NEXT(a_esc_clears, accept && esc_pending_reg, !esc_pending_reg, "escape pending did not clear after the literal byte")

endmodule

@@ design/erx_queue.sv @@
module erx_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  erx_pkg::sym_t    push_sym,
    input  logic             pop,
    output erx_pkg::sym_t    head_sym,
    output erx_pkg::qstat_t  qstat
);

`include "escaped_frame_receiver_crc_check_unit_macros.svh"

    erx_pkg::sym_t                  mem_reg [erx_pkg::QUEUE_DEPTH];
    logic [erx_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [erx_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [erx_pkg::QCNT_W-1:0]     cnt_reg;
    logic [erx_pkg::QCNT_W-1:0]     cnt_next;

    assign qstat.full  = (cnt_reg == erx_pkg::QCNT_W'(erx_pkg::QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head_sym    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_sym;
        end
    end

    `ERX_ASSERT_SAME(a_no_overflow, push && !pop, !qstat.full, "symbol queue written while full")
    `ERX_ASSERT_SAME(a_no_underflow, pop, !qstat.empty, "symbol queue read while empty")

endmodule

@@ design/erx_engine.sv @@
module erx_engine #(
    parameter int unsigned FRAME_CAPACITY = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  erx_pkg::qstat_t  qstat,
    input  erx_pkg::sym_t    head_sym,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output erx_pkg::result_t result
);

`include "escaped_frame_receiver_crc_check_unit_macros.svh"

    localparam int unsigned CNT_W = $clog2(FRAME_CAPACITY + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [7:0]         dly0_reg;
    logic [7:0]         dly0_next;
    logic [7:0]         dly1_reg;
    logic [7:0]         dly1_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    erx_pkg::result_t   out_reg;
    erx_pkg::result_t   out_next;
    logic               produce;

    // The result register takes a new beat when it is empty or being drained.
    assign pop      = !qstat.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        count_next = count_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        crc_next   = crc_reg;
        produce    = 1'b0;
        out_next   = '0;
        if (pop)
        begin
            if (head_sym.is_end)
            begin
                produce               = 1'b1;
                out_next.kind         = erx_pkg::KIND_STATUS;
                out_next.frame_length = erx_pkg::LEN_W'(count_reg);
                if (count_reg < CNT_W'(erx_pkg::MIN_FRAME_LEN))
                begin
                    out_next.frame_status = erx_pkg::STATUS_TOO_SHORT;
                end
                else if ({dly1_reg, dly0_reg} == crc_reg)
                begin
                    out_next.frame_status = erx_pkg::STATUS_OK;
                end
                else
                begin
                    out_next.frame_status = erx_pkg::STATUS_CRC_ERROR;
                end
                count_next = '0;
                dly0_next  = '0;
                dly1_next  = '0;
                crc_next   = '0;
            end
            else if (count_reg != CNT_W'(FRAME_CAPACITY))
            begin
                if (count_reg >= CNT_W'(2))
                begin
                    produce                  = 1'b1;
                    out_next.kind            = erx_pkg::KIND_PAYLOAD;
                    out_next.data            = dly0_reg;
                    out_next.is_command_code = (count_reg == CNT_W'(2));
                    crc_next = erx_pkg::crc16_arc_byte(crc_reg, dly0_reg);
                end
                dly0_next  = dly1_reg;
                dly1_next  = head_sym.data;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = produce;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dly0_reg      <= '0;
            dly1_reg      <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dly0_reg      <= dly0_next;
            dly1_reg      <= dly1_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            out_reg <= out_next;
        end
    end

    `ERX_ASSERT_SAME(a_count_cap, 1'b1, count_reg <= CNT_W'(FRAME_CAPACITY), "frame byte count above capacity")
    `ERX_ASSERT_NEXT(a_end_clears, pop && head_sym.is_end, count_reg == '0 && crc_reg == '0, "frame state not cleared after end")

endmodule

@@ design/escaped_frame_receiver_crc_check_unit.sv @@
// Channel  | Direction | Beat contents
// ---------+-----------+----------------------------------------------------------
// s_*      | in        | tdata[7:0] = rx_byte
// m_*      | out       | tuser = {is_command_code, out_kind}; tdata = {length, status, byte}
// cfg_*    | in        | write enable, register index (0 escape, 1 end), 8-bit data
//
// A received byte is accepted while the queue is not full, at one byte per cycle.
// The front end strips escapes and hands decoded symbols to the frame engine
// through a four-entry queue, so a stalled output does not stop input at once.
// A status result is registered at the edge that pops its end symbol; a payload
// byte as it leaves the two-byte delay. Reset clears the escape state, the queue,
// the frame state and loads the default escape (241) and end (242) characters.
module escaped_frame_receiver_crc_check_unit #(
    parameter int unsigned FRAME_CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes, user-made while the receiver is idle; the block does not check.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Raw bytes from the serial link.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // Payload bytes and end-of-frame status.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_byte, [9:8] frame_status,
                                    // [18:10] frame_length, [23:19] zero
    output logic [1:0]  m_tuser     // [0] out_kind, [1] is_command_code
);

    erx_pkg::qstat_t  qstat;
    erx_pkg::sym_t    push_sym;
    erx_pkg::sym_t    head_sym;
    erx_pkg::result_t result;
    logic             push;
    logic             pop;

    // Escape removal and end detection; one symbol per accepted byte at most.
    erx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .qstat     (qstat),
        .push      (push),
        .push_sym  (push_sym)
    );

    // Decouples the byte decoder from the frame engine.
    erx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sym (push_sym),
        .pop      (pop),
        .head_sym (head_sym),
        .qstat    (qstat)
    );

    // Frame storage count, two-byte CRC delay, running CRC and result register.
    erx_engine #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head_sym (head_sym),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // Status beats carry a zero byte; payload beats carry zero status and length.
    assign m_tdata = {5'd0, result.frame_length, result.frame_status, result.data};
    assign m_tuser = {result.is_command_code, result.kind};

endmodule
